>>> src/zbps_pkg.sv
// Shared types and constants of the depth-buffered pixel store.
`default_nettype none

package zbps_pkg;

  localparam int COL_W   = 16;
  localparam int CFG_W   = 12;
  localparam int DEPTH_W = 31;
  localparam int POS_W   = 8;
  localparam int OUT_W   = 8;
  localparam int WORD_W  = 4 * COL_W + DEPTH_W;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CFG_CLEAR_RED   = 2'd0,
    CFG_CLEAR_GREEN = 2'd1,
    CFG_CLEAR_BLUE  = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic capture;
    logic sweep;
    logic exec;
    logic report;
  } ctl_cmd_t;

  typedef struct packed {
    logic start_clear;
    logic sweep_last;
  } ctl_status_t;

endpackage

`default_nettype wire

>>> src/zbuffer_pixel_store.sv
// Read, write or clear with a single transfer accepted when start is high and busy low.
// Write and read: the memory is read and registered, then the depth test and write-back
// run and the result strobes; busy stays high meanwhile, so no new transfer is taken first.
// Clear: a sweep of all WIDTH*HEIGHT pixels, one pixel a cycle, then the result strobe.
// Reset: synchronous rst_n; a clearing pass over all WIDTH*HEIGHT pixels follows, busy high.
// Results are never stalled: out_valid lasts one cycle.
`default_nettype none

module zbuffer_pixel_store #(
  parameter int WIDTH  = 256,
  parameter int HEIGHT = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [zbps_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        in_action,
  input  wire logic [zbps_pkg::POS_W-1:0]        in_pos_x,
  input  wire logic [zbps_pkg::POS_W-1:0]        in_pos_y,
  input  wire logic signed [zbps_pkg::COL_W-1:0] in_red,
  input  wire logic signed [zbps_pkg::COL_W-1:0] in_green,
  input  wire logic signed [zbps_pkg::COL_W-1:0] in_blue,
  input  wire logic signed [zbps_pkg::COL_W-1:0] in_alpha,
  input  wire logic [zbps_pkg::DEPTH_W-1:0]      in_depth,
  output logic                                   out_valid,
  output logic [zbps_pkg::OUT_W-1:0]             out_red,
  output logic [zbps_pkg::OUT_W-1:0]             out_green,
  output logic [zbps_pkg::OUT_W-1:0]             out_blue,
  output logic signed [zbps_pkg::COL_W-1:0]      out_alpha,
  output logic [zbps_pkg::DEPTH_W-1:0]           out_depth,
  output logic                                   out_was_written
);

  zbps_pkg::ctl_cmd_t    cmd;
  zbps_pkg::ctl_status_t status;

  zbps_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  zbps_datapath #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_action       (in_action),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_alpha        (in_alpha),
    .in_depth        (in_depth),
    .out_valid       (out_valid),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_alpha       (out_alpha),
    .out_depth       (out_depth),
    .out_was_written (out_was_written)
  );

`ifndef ASSERT_OFF
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after a transfer");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without work in progress");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_no_sweep_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sweep |-> !cmd.exec && !cmd.capture)
    else $error("pixel access during clear sweep");
`endif

endmodule

`default_nettype wire

>>> src/zbps_ctrl.sv
// Controller state machine: sequences transfers, pixel accesses and clear sweeps.
`default_nettype none

module zbps_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire zbps_pkg::ctl_status_t status,
  output zbps_pkg::ctl_cmd_t        cmd,
  output logic                      busy
);

  zbps_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= zbps_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      zbps_pkg::ST_INIT: begin
        if (status.sweep_last) state_nxt = zbps_pkg::ST_IDLE;
      end
      zbps_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = status.start_clear ? zbps_pkg::ST_CLEAR : zbps_pkg::ST_FETCH;
        end
      end
      zbps_pkg::ST_FETCH: state_nxt = zbps_pkg::ST_EXEC;
      zbps_pkg::ST_EXEC:  state_nxt = zbps_pkg::ST_IDLE;
      zbps_pkg::ST_CLEAR: begin
        if (status.sweep_last) state_nxt = zbps_pkg::ST_IDLE;
      end
      default: state_nxt = zbps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      zbps_pkg::ST_INIT: cmd.sweep = 1'b1;
      zbps_pkg::ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      zbps_pkg::ST_FETCH: ;
      zbps_pkg::ST_EXEC:  cmd.exec = 1'b1;
      zbps_pkg::ST_CLEAR: begin
        cmd.sweep  = 1'b1;
        // report only for a requested clear, not the one after reset
        cmd.report = status.sweep_last;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

>>> src/zbps_datapath.sv
// Datapath: configuration registers, pixel memory, depth test and read formatting.
`default_nettype none

module zbps_datapath #(
  parameter int WIDTH  = 256,
  parameter int HEIGHT = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire zbps_pkg::ctl_cmd_t                cmd,
  output zbps_pkg::ctl_status_t                  status,
  input  wire logic                              cfg_we,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [zbps_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic [1:0]                        in_action,
  input  wire logic [zbps_pkg::POS_W-1:0]        in_pos_x,
  input  wire logic [zbps_pkg::POS_W-1:0]        in_pos_y,
  input  wire logic signed [zbps_pkg::COL_W-1:0] in_red,
  input  wire logic signed [zbps_pkg::COL_W-1:0] in_green,
  input  wire logic signed [zbps_pkg::COL_W-1:0] in_blue,
  input  wire logic signed [zbps_pkg::COL_W-1:0] in_alpha,
  input  wire logic [zbps_pkg::DEPTH_W-1:0]      in_depth,
  output logic                                   out_valid,
  output logic [zbps_pkg::OUT_W-1:0]             out_red,
  output logic [zbps_pkg::OUT_W-1:0]             out_green,
  output logic [zbps_pkg::OUT_W-1:0]             out_blue,
  output logic signed [zbps_pkg::COL_W-1:0]      out_alpha,
  output logic [zbps_pkg::DEPTH_W-1:0]           out_depth,
  output logic                                   out_was_written
);

  localparam int N  = WIDTH * HEIGHT;
  localparam int AW = $clog2(N);
  localparam int CW = zbps_pkg::COL_W;
  localparam int DW = zbps_pkg::DEPTH_W;
  localparam int OW = zbps_pkg::OUT_W;
  localparam int WW = zbps_pkg::WORD_W;

  // clamp to 0..4095, then keep bits 11:4
  function automatic logic [OW-1:0] to_eight(input logic [CW-1:0] v);
    logic [OW-1:0] res;
    if (v[CW-1]) begin
      res = '0;
    end else if (v[CW-2:zbps_pkg::CFG_W] != '0) begin
      res = '1;
    end else begin
      res = v[zbps_pkg::CFG_W-1:zbps_pkg::CFG_W-OW];
    end
    return res;
  endfunction

  logic [zbps_pkg::CFG_W-1:0] clr_red_r, clr_green_r, clr_blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_red_r   <= zbps_pkg::CFG_W'(2032);
      clr_green_r <= zbps_pkg::CFG_W'(1776);
      clr_blue_r  <= zbps_pkg::CFG_W'(1520);
    end else if (cfg_we) begin
      case (zbps_pkg::cfg_index_t'(cfg_index))
        zbps_pkg::CFG_CLEAR_RED:   clr_red_r   <= cfg_data;
        zbps_pkg::CFG_CLEAR_GREEN: clr_green_r <= cfg_data;
        zbps_pkg::CFG_CLEAR_BLUE:  clr_blue_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured item
  logic [1:0]      act_r;
  logic            inside_r;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic [4*CW-1:0] colour_r;
  logic [DW-1:0]   depth_r;
  logic            inside_nxt;

  always_comb begin
    inside_nxt = (32'(in_pos_x) < WIDTH) && (32'(in_pos_y) < HEIGHT);
    addr_nxt   = inside_nxt ? AW'(32'(in_pos_y) * WIDTH + 32'(in_pos_x)) : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r    <= in_action;
      inside_r <= inside_nxt;
      addr_r   <= addr_nxt;
      colour_r <= {in_alpha, in_blue, in_green, in_red};
      depth_r  <= in_depth;
    end
  end

  assign status.start_clear = (zbps_pkg::action_t'(in_action) == zbps_pkg::ACT_CLEAR);

  // clear sweep counter; held at zero outside a sweep
  logic [AW-1:0] sweep_r;
  assign status.sweep_last = (sweep_r == AW'(N - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (cmd.sweep && !status.sweep_last) begin
      sweep_r <= sweep_r + 1'b1;
    end else begin
      sweep_r <= '0;
    end
  end

  // pixel memory: depth in the top bits, then alpha, blue, green, red
  logic [WW-1:0] mem [N];
  logic [WW-1:0] rd_r;
  logic [DW-1:0] rd_depth;
  logic          pass;
  logic [WW-1:0] clear_word;

  assign rd_depth   = rd_r[WW-1:4*CW];
  assign pass       = (zbps_pkg::action_t'(act_r) == zbps_pkg::ACT_WRITE) && inside_r &&
                      (depth_r <= rd_depth);
  assign clear_word = {zbps_pkg::DEPTH_MAX, CW'(0),
                       CW'(clr_blue_r), CW'(clr_green_r), CW'(clr_red_r)};

  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      mem[sweep_r] <= clear_word;
    end else if (cmd.exec && pass) begin
      mem[addr_r] <= {depth_r, colour_r};
    end
    rd_r <= mem[addr_r];
  end

  // result registers
  logic          valid_r;
  logic [OW-1:0] red_r, green_r, blue_r, red_nxt, green_nxt, blue_nxt;
  logic [CW-1:0] alpha_r, alpha_nxt;
  logic [DW-1:0] odepth_r, odepth_nxt;
  logic          wr_r, wr_nxt;

  always_comb begin
    red_nxt    = '0;
    green_nxt  = '0;
    blue_nxt   = '0;
    alpha_nxt  = '0;
    odepth_nxt = '0;
    wr_nxt     = 1'b0;
    if (cmd.exec) begin
      wr_nxt = pass;
      if ((zbps_pkg::action_t'(act_r) == zbps_pkg::ACT_READ) && inside_r) begin
        red_nxt    = to_eight(rd_r[CW-1:0]);
        green_nxt  = to_eight(rd_r[2*CW-1:CW]);
        blue_nxt   = to_eight(rd_r[3*CW-1:2*CW]);
        alpha_nxt  = rd_r[4*CW-1:3*CW];
        odepth_nxt = rd_depth;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.exec | cmd.report;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec || cmd.report) begin
      red_r    <= red_nxt;
      green_r  <= green_nxt;
      blue_r   <= blue_nxt;
      alpha_r  <= alpha_nxt;
      odepth_r <= odepth_nxt;
      wr_r     <= wr_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_red         = red_r;
  assign out_green       = green_r;
  assign out_blue        = blue_r;
  assign out_alpha       = alpha_r;
  assign out_depth       = odepth_r;
  assign out_was_written = wr_r;

endmodule

`default_nettype wire
